// File: hdl/fpk_pkg.sv
`default_nettype none

package fpk_pkg;

	// Queue depth used when the top level is not told otherwise.
	localparam int DEPTH_DEFAULT = 16;

	// Field widths of the request and result items.
	localparam int KIND_W   = 2;
	localparam int CODE_W   = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PROMOTE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

	// One request item.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CODE_W-1:0] key_code;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [CODE_W-1:0]   head_code;
		logic [COUNT_W-1:0]  match_count;
		logic [COUNT_W-1:0]  occupancy;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic pop_capture;
		logic pass;
		logic fill;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic pass_busy;
		logic mcnt_zero;
		logic fill_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// File: hdl/fpk_stream_if.sv
`default_nettype none

// Valid/ready channel carrying one item of type T.
interface fpk_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/fpk_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module fpk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/fpk_datapath.sv
`default_nettype none

// Circular queue storage, pointers, promote pass and result register.
module fpk_datapath #(
	parameter int DEPTH = fpk_pkg::DEPTH_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fpk_pkg::req_t      req_data,
	input  wire fpk_pkg::ctrl_cmd_t cmd,
	output fpk_pkg::ctrl_sts_t      sts,
	input  wire logic               rsp_ready,
	output logic                    rsp_valid,
	output fpk_pkg::rsp_t           rsp_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// Queue pointers and fill level.
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	// Promote pass state.
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CW-1:0] rem_q;
	logic          rdv_s1;
	logic [CW-1:0] mcnt_q;
	logic [CW-1:0] fill_q;

	// Captured request and partial result.
	logic [fpk_pkg::KIND_W-1:0]   kind_q;
	logic [fpk_pkg::CODE_W-1:0]   key_q;
	logic [fpk_pkg::STATUS_W-1:0] status_q;
	logic [fpk_pkg::CODE_W-1:0]   head_code_q;

	// Output register.
	logic          rsp_valid_q;
	fpk_pkg::rsp_t rsp_data_q;

	// RAM port signals.
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [fpk_pkg::CODE_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [fpk_pkg::CODE_W-1:0] ram_rdata;

	logic is_empty;
	logic is_full;
	logic rd_match;
	logic rem_nz;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));
	assign rd_match = (ram_rdata == key_q);
	assign rem_nz   = (rem_q != '0);

	// RAM port selection: push at the tail, pop at the head, pass and refill
	// walking from the tail back toward the head.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_ptr_q;
		ram_wdata = key_q;
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q;
		if (cmd.accept) begin
			if (req_data.kind == fpk_pkg::KIND_PUSH && !is_full) begin
				ram_we    = 1'b1;
				ram_waddr = tail_q;
				ram_wdata = req_data.key_code;
			end
			if (req_data.kind == fpk_pkg::KIND_POP && !is_empty) begin
				ram_re    = 1'b1;
				ram_raddr = head_q;
			end
		end
		if (cmd.pass) begin
			ram_re    = rem_nz;
			ram_we    = rdv_s1 && !rd_match;
			ram_wdata = ram_rdata;
		end
		if (cmd.fill) begin
			ram_we = 1'b1;
		end
	end

	fpk_ram #(
		.WIDTH(fpk_pkg::CODE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control registers: pointers, counts and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			rem_q       <= '0;
			rdv_s1      <= 1'b0;
			mcnt_q      <= '0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				mcnt_q <= '0;
				fill_q <= '0;
				rdv_s1 <= 1'b0;
				case (req_data.kind)
					fpk_pkg::KIND_PUSH: begin
						if (!is_full) begin
							tail_q  <= ptr_inc(tail_q);
							count_q <= count_q + CW'(1);
						end
					end
					fpk_pkg::KIND_POP: begin
						if (!is_empty) begin
							head_q  <= ptr_inc(head_q);
							count_q <= count_q - CW'(1);
						end
					end
					fpk_pkg::KIND_PROMOTE: begin
						rem_q <= count_q;
					end
					default: begin
					end
				endcase
			end
			if (cmd.pass) begin
				rdv_s1 <= rem_nz;
				if (rem_nz) begin
					rem_q <= rem_q - CW'(1);
				end
				if (rdv_s1 && rd_match) begin
					mcnt_q <= mcnt_q + CW'(1);
				end
			end
			if (cmd.fill) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q      <= req_data.kind;
			key_q       <= req_data.key_code;
			head_code_q <= '0;
			rd_ptr_q    <= ptr_dec(tail_q);
			wr_ptr_q    <= ptr_dec(tail_q);
			if (req_data.kind == fpk_pkg::KIND_PUSH && is_full) begin
				status_q <= fpk_pkg::STATUS_FULL;
			end else if (req_data.kind == fpk_pkg::KIND_POP && is_empty) begin
				status_q <= fpk_pkg::STATUS_EMPTY;
			end else begin
				status_q <= fpk_pkg::STATUS_OK;
			end
		end
		if (cmd.pop_capture) begin
			head_code_q <= ram_rdata;
		end
		if (cmd.pass) begin
			if (rem_nz) begin
				rd_ptr_q <= ptr_dec(rd_ptr_q);
			end
			if (rdv_s1 && !rd_match) begin
				wr_ptr_q <= ptr_dec(wr_ptr_q);
			end
		end
		if (cmd.fill) begin
			wr_ptr_q <= ptr_dec(wr_ptr_q);
		end
		if (cmd.load_out) begin
			rsp_data_q.status <= (kind_q == fpk_pkg::KIND_PROMOTE && mcnt_q == '0)
				? fpk_pkg::STATUS_NOT_FOUND : status_q;
			rsp_data_q.head_code   <= head_code_q;
			rsp_data_q.match_count <= fpk_pkg::COUNT_W'(mcnt_q);
			rsp_data_q.occupancy   <= fpk_pkg::COUNT_W'(count_q);
		end
	end

	// Status to the controller.
	assign sts.empty     = is_empty;
	assign sts.pass_busy = rem_nz || rdv_s1;
	assign sts.mcnt_zero = (mcnt_q == '0);
	assign sts.fill_done = (fill_q == mcnt_q);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

`default_nettype wire

// File: hdl/fpk_ctrl.sv
`default_nettype none

// Sequencer: one request item at a time through decode, pop read or pass and refill, then result.
module fpk_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	input  wire logic [fpk_pkg::KIND_W-1:0] req_kind,
	output logic                            req_ready,
	input  wire fpk_pkg::ctrl_sts_t         sts,
	output fpk_pkg::ctrl_cmd_t              cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_POP_RD  = 3'd1;
	localparam logic [2:0] ST_PR_RUN  = 3'd2;
	localparam logic [2:0] ST_PR_FILL = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (req_kind)
						fpk_pkg::KIND_POP:     state_d = sts.empty ? ST_DONE : ST_POP_RD;
						fpk_pkg::KIND_PROMOTE: state_d = sts.empty ? ST_DONE : ST_PR_RUN;
						default:               state_d = ST_DONE;
					endcase
				end
			end
			ST_POP_RD: begin
				cmd.pop_capture = 1'b1;
				state_d         = ST_DONE;
			end
			ST_PR_RUN: begin
				cmd.pass = 1'b1;
				if (!sts.pass_busy) begin
					state_d = sts.mcnt_zero ? ST_DONE : ST_PR_FILL;
				end
			end
			ST_PR_FILL: begin
				if (sts.fill_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.fill = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/fifo_with_promote_by_key_unit.sv
// Bounded queue of 16-bit codes with push, pop and promote-by-key requests.
// Requests arrive on req (kind, key_code); every request gives exactly one
// result item on rsp (status, head_code, match_count, occupancy).
// Both channels use valid/ready; an item moves when both are high.
// Entries live in a circular buffer in a RAM with one write and one
// registered read port, addressed by head and tail pointers.
// Promote walks the stored entries from tail to head, one RAM read a cycle,
// compacting the non-matching ones toward the tail, then writes the key into
// the freed front slots through the single write port.
// One request is in flight at a time; req.ready is high only while idle, so
// a new request is taken only after the one before has loaded its result.
// The next request may be taken while an earlier result still waits in the
// output register. If the receiver stalls rsp, the result holds and the block
// stops before presenting the following one.
// Reset empties the queue at once; the RAM contents are not cleared.
`default_nettype none

module fifo_with_promote_by_key_unit #(
	parameter int DEPTH = fpk_pkg::DEPTH_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	fpk_stream_if.sink   req,
	fpk_stream_if.source rsp
);

	fpk_pkg::ctrl_cmd_t cmd;
	fpk_pkg::ctrl_sts_t sts;
	fpk_pkg::req_t      req_data;
	fpk_pkg::rsp_t      rsp_data;
	logic               req_ready;
	logic               rsp_valid;

	assign req_data  = req.data;
	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;
	assign rsp.data  = rsp_data;

	// Controller.
	fpk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_kind (req_data.kind),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath with the queue RAM.
	fpk_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req_data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_ready(rsp.ready),
		.rsp_valid(rsp_valid),
		.rsp_data (rsp_data)
	);

	// Only one request is in flight: an accept is never followed directly by another.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req_ready) |=> !req_ready)
	else $error("request accepted while another is in flight");

	// A new result never overwrites one the receiver has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!rsp_valid || rsp.ready))
	else $error("result register overwritten");

	// Empty and full results carry no head code and no match count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_data.status == fpk_pkg::STATUS_EMPTY
			|| rsp_data.status == fpk_pkg::STATUS_FULL))
		|-> (rsp_data.head_code == '0 && rsp_data.match_count == '0))
	else $error("error result carries data");

	// A request is never accepted in the same cycle as a result load.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !cmd.load_out)
	else $error("accept and result load in one cycle");

endmodule

`default_nettype wire
